@@ src/wpm_pkg.sv @@
// Shared types and byte constants for the wildcard pattern match unit.
package wpm_pkg;

  // Item kinds carried on the input tuser field
  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_TEXT   = 2'd2,
    KIND_END    = 2'd3
  } wpm_kind_t;

  // Wildcard bytes in the mask
  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;

  // Classified item passed from the front end to the matcher
  typedef struct packed {
    wpm_kind_t  kind;
    logic [7:0] ch;
    logic       is_star;
  } wpm_item_t;

endpackage

@@ src/wpm_front.sv @@
// Input stage: registers each incoming transaction and classifies its byte.
module wpm_front
  import wpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_ch,
  output logic       out_valid,
  input  logic       out_ready,
  output wpm_item_t  out_item
);

  logic      held;
  wpm_item_t item;

  // Accept when the stage is empty or drains this cycle
  assign in_ready  = !held || out_ready;
  assign out_valid = held;
  assign out_item  = item;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  // Capture and classify the payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.kind    <= wpm_kind_t'(in_kind);
      item.ch      <= in_ch;
      item.is_star <= (in_ch == STAR_BYTE);
    end
  end

endmodule

@@ src/wpm_queue.sv @@
// Short FIFO of classified items between the front end and the matcher.
module wpm_queue
  import wpm_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  wpm_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output wpm_item_t out_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  wpm_item_t       slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

@@ src/wpm_back.sv @@
// Matcher: mask store, active position set update and result register.
module wpm_back
  import wpm_pkg::*;
#(
  parameter int MAX_MASK = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  wpm_item_t  in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_matched,
  output logic       out_overflow
);

  localparam int W  = MAX_MASK + 1;
  localparam int LV = $clog2(W);
  localparam int IW = (MAX_MASK > 1) ? $clog2(MAX_MASK) : 1;
  localparam int LW = $clog2(MAX_MASK + 1);

  logic [7:0]          mask_store [MAX_MASK];
  logic [LW-1:0]       mask_length;
  logic [MAX_MASK-1:0] live;
  logic [MAX_MASK-1:0] star;
  logic [W-1:0]        active;
  logic                overflow;

  logic [LW-1:0]       length_next;
  logic [MAX_MASK-1:0] live_next;
  logic [MAX_MASK-1:0] star_next;
  logic                overflow_next;
  logic                has_room;
  logic                take;
  logic [MAX_MASK-1:0] hold_pos;
  logic [MAX_MASK-1:0] adv_pos;
  logic [W-1:0]        stepped;
  logic [W-1:0]        seed;
  logic [W-1:0]        cg [LV+1];
  logic [W-1:0]        cp [LV+1];

  assign has_room = (mask_length < LW'(MAX_MASK));

  // Stall only a result while the output register is still full
  assign in_ready = (in_item.kind != KIND_END) || !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // Step each live active position over the text byte
  always_comb begin
    for (int i = 0; i < MAX_MASK; i++) begin
      hold_pos[i] = active[i] && live[i] && star[i];
      adv_pos[i]  = active[i] && live[i] && !star[i] &&
                    ((mask_store[i] == ANY_BYTE) || (mask_store[i] == in_item.ch));
    end
    stepped = {1'b0, hold_pos} | {adv_pos, 1'b0};
  end

  // Work out mask bookkeeping for this item
  always_comb begin
    length_next   = mask_length;
    live_next     = live;
    star_next     = star;
    overflow_next = overflow;
    seed          = W'(1);
    unique case (in_item.kind)
      KIND_CLEAR: begin
        length_next   = '0;
        live_next     = '0;
        star_next     = '0;
        overflow_next = 1'b0;
      end
      KIND_APPEND: begin
        if (has_room) begin
          length_next                   = mask_length + 1'b1;
          live_next[mask_length[IW-1:0]] = 1'b1;
          star_next[mask_length[IW-1:0]] = in_item.is_star;
        end else begin
          overflow_next = 1'b1;
        end
      end
      KIND_TEXT: begin
        seed = stepped;
      end
      KIND_END: begin
        seed = W'(1);
      end
      default: begin
        seed = W'(1);
      end
    endcase
  end

  // Close the set over runs of stars with a prefix network
  always_comb begin
    cg[0] = seed;
    cp[0] = {star_next, 1'b0};
    for (int l = 0; l < LV; l++) begin
      for (int j = 0; j < W; j++) begin
        if (j >= (1 << l)) begin
          cg[l+1][j] = cg[l][j] | (cp[l][j] & cg[l][j-(1<<l)]);
          cp[l+1][j] = cp[l][j] & cp[l][j-(1<<l)];
        end else begin
          cg[l+1][j] = cg[l][j];
          cp[l+1][j] = cp[l][j];
        end
      end
    end
  end

  // Hold matcher state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_length  <= '0;
      live         <= '0;
      star         <= '0;
      overflow     <= 1'b0;
      active       <= W'(1);
      out_valid    <= 1'b0;
      out_matched  <= 1'b0;
      out_overflow <= 1'b0;
    end else begin
      if (take) begin
        mask_length <= length_next;
        live        <= live_next;
        star        <= star_next;
        overflow    <= overflow_next;
        active      <= cg[LV];
      end
      if (take && (in_item.kind == KIND_END)) begin
        out_valid    <= 1'b1;
        out_matched  <= active[mask_length] && !overflow;
        out_overflow <= overflow;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Write mask bytes
  always_ff @(posedge clk) begin
    if (take && (in_item.kind == KIND_APPEND) && has_room) begin
      mask_store[mask_length[IW-1:0]] <= in_item.ch;
    end
  end

  // Active positions never lie past the end of the mask
  assert property (@(posedge clk) disable iff (rst)
    (active & ~{live, 1'b1}) == '0)
    else $error("active position beyond mask length");

  // Star flags only mark stored positions
  assert property (@(posedge clk) disable iff (rst)
    (star & ~live) == '0)
    else $error("star flag on an unstored position");

  // Live positions track the stored length
  assert property (@(posedge clk) disable iff (rst)
    $countones(live) == int'(mask_length))
    else $error("live positions disagree with mask length");

  // Overflow only once the store is full
  assert property (@(posedge clk) disable iff (rst)
    overflow |-> (mask_length == LW'(MAX_MASK)))
    else $error("overflow flagged with room left");

endmodule

@@ src/wildcard_pattern_match_unit.sv @@
// Top level of the wildcard pattern match unit: front end, queue and matcher.
//
//  Channel   Direction  Contents
//  s_axis    in         tuser[1:0] kind, tdata[7:0] ch
//  m_axis    out        tdata[0] matched, tdata[1] mask_overflow, tdata[7:2] zero
//
// One item per cycle sustained while m_axis takes results: the matcher updates its
// state for every kind as it accepts it, limited by the byte compare and the
// star-closure prefix network. With the queue empty, a result passes the input
// register, the queue and the result register before it is valid on m_axis.
// Reset empties the mask, clears overflow and flushes the input stage and queue.
// A stalled result stops end-of-text items; earlier mask and text items drain on.
module wildcard_pattern_match_unit
  import wpm_pkg::*;
#(
  parameter int MAX_MASK    = 32,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] ch
  input  logic [1:0] s_axis_tuser,   // [1:0] kind
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] matched, [1] mask_overflow, [7:2] zero
);

  logic      front_valid;
  logic      front_ready;
  wpm_item_t front_item;
  logic      queue_valid;
  logic      queue_ready;
  wpm_item_t queue_item;
  logic      matched;
  logic      overflow;

  wpm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_kind   (s_axis_tuser),
    .in_ch     (s_axis_tdata),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_item  (front_item)
  );

  wpm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_item   (front_item),
    .out_valid (queue_valid),
    .out_ready (queue_ready),
    .out_item  (queue_item)
  );

  wpm_back #(
    .MAX_MASK (MAX_MASK)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (queue_valid),
    .in_ready     (queue_ready),
    .in_item      (queue_item),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_matched  (matched),
    .out_overflow (overflow)
  );

  // Pack the result transaction
  assign m_axis_tdata = {6'b0, overflow, matched};

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the wildcard pattern match unit.
module testbench
  import wpm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MASK_DEPTH  = 32;
  localparam int ITEM_TARGET = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 12;
  localparam int CYCLE_LIMIT = 300000;

  // One end-of-text verdict as carried on m_axis_tdata
  typedef struct packed {
    logic matched;
    logic overflow;
  } match_verdict_t;

  // Directed stimulus row; expected verdict is used only when fixed is set
  typedef struct packed {
    wpm_kind_t  kind;
    logic [7:0] ch;
    logic [5:0] reps;
    logic       fixed;
    logic       matched;
    logic       overflow;
  } plan_row_t;

  localparam int PLAN_ROWS = 33;
  localparam plan_row_t PLAN [0:PLAN_ROWS-1] = '{
    '{KIND_END,    8'h00,     6'd1,  1'b1, 1'b1, 1'b0}, // empty text against empty mask
    '{KIND_TEXT,   8'h00,     6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_END,    8'hFF,     6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_APPEND, STAR_BYTE, 6'd2,  1'b0, 1'b0, 1'b0},
    '{KIND_END,    8'h00,     6'd1,  1'b1, 1'b1, 1'b0}, // empty text, mask of stars
    '{KIND_TEXT,   8'h00,     6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_TEXT,   8'hFF,     6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_END,    8'h00,     6'd1,  1'b1, 1'b1, 1'b0},
    '{KIND_CLEAR,  8'hFF,     6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_APPEND, 8'h61,     6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_APPEND, ANY_BYTE,  6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_APPEND, 8'hFF,     6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_APPEND, 8'h00,     6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_APPEND, STAR_BYTE, 6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_TEXT,   8'h61,     6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_TEXT,   8'h55,     6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_TEXT,   8'hFF,     6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_TEXT,   8'h00,     6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_TEXT,   STAR_BYTE, 6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_END,    8'h00,     6'd1,  1'b0, 1'b0, 1'b0},
    // upper-case text against lower-case mask, then a mask byte mid-text
    '{KIND_TEXT,   8'h41,     6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_TEXT,   8'h55,     6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_APPEND, STAR_BYTE, 6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_END,    8'h00,     6'd1,  1'b0, 1'b0, 1'b0},
    // fill the mask to capacity, then one byte too many
    '{KIND_CLEAR,  8'h00,     6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_APPEND, 8'h7A,     6'd32, 1'b0, 1'b0, 1'b0},
    '{KIND_TEXT,   8'h7A,     6'd32, 1'b0, 1'b0, 1'b0},
    '{KIND_END,    8'h00,     6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_APPEND, ANY_BYTE,  6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_END,    8'h00,     6'd1,  1'b1, 1'b0, 1'b1}, // overflowed mask
    '{KIND_TEXT,   8'h7A,     6'd1,  1'b0, 1'b0, 1'b0},
    '{KIND_END,    8'hFF,     6'd1,  1'b1, 1'b0, 1'b1},
    '{KIND_CLEAR,  8'h00,     6'd1,  1'b1, 1'b1, 1'b0}  // fixed flag unused on clear
  };

  // Idle percentages per phase: none, sender, receiver, both
  localparam int SEND_IDLE [0:3] = '{0, 81, 0, 13};
  localparam int RECV_IDLE [0:3] = '{0, 0, 81, 13};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic [1:0] s_axis_tuser = 2'd0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  // Matcher state mirrored by the predictor
  logic [7:0]  pat_bytes [MASK_DEPTH];
  logic [5:0]  pat_len = '0;
  logic [32:0] live_set = 33'd1;
  logic        pat_overflow = 1'b0;

  match_verdict_t verdict_q [$];
  int          items_sent = 0;
  int          error_count = 0;
  int          cycle_count = 0;
  int          phase = 0;
  bit          pressure_go = 1'b0;
  logic        hold_off = 1'b0;

  wildcard_pattern_match_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk = ~clk;

  // Extend every active position over the run of stars that follows it
  function automatic logic [32:0] close_stars(logic [32:0] set);
    for (int i = 0; i < MASK_DEPTH; i++) begin
      if (i < pat_len && set[i] && pat_bytes[i] == STAR_BYTE) set[i+1] = 1'b1;
    end
    return set;
  endfunction

  // Advance the mirrored matcher by one transaction
  function automatic void step_matcher(input wpm_kind_t kind, input logic [7:0] ch,
                                       output bit has_verdict,
                                       output match_verdict_t verdict);
    logic [32:0] nxt;
    has_verdict = 1'b0;
    verdict = '0;
    nxt = '0;
    case (kind)
      KIND_CLEAR: begin
        pat_len = '0;
        pat_overflow = 1'b0;
        live_set = close_stars(33'd1);
      end
      KIND_APPEND: begin
        if (pat_len < MASK_DEPTH) begin
          pat_bytes[pat_len[4:0]] = ch;
          pat_len = pat_len + 6'd1;
        end else begin
          pat_overflow = 1'b1;
        end
        live_set = close_stars(33'd1);
      end
      KIND_TEXT: begin
        for (int i = 0; i < MASK_DEPTH; i++) begin
          if (i < pat_len && live_set[i]) begin
            if (pat_bytes[i] == STAR_BYTE) nxt[i] = 1'b1;
            else if (pat_bytes[i] == ANY_BYTE || pat_bytes[i] == ch) nxt[i+1] = 1'b1;
          end
        end
        live_set = close_stars(nxt);
      end
      default: begin
        has_verdict = 1'b1;
        verdict.matched = live_set[pat_len] && !pat_overflow;
        verdict.overflow = pat_overflow;
        live_set = close_stars(33'd1);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("cycle %0d: %s mismatch: got %0d, expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // Offer one item, hold it until the handshake, then predict its verdict
  task automatic send_item(input wpm_kind_t kind, input logic [7:0] ch, input bit fixed,
                           input match_verdict_t fixed_verdict);
    bit has_verdict;
    match_verdict_t verdict;
    phase = (items_sent / 250) % 4;
    while ($urandom_range(99) < SEND_IDLE[phase]) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= ch;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    step_matcher(kind, ch, has_verdict, verdict);
    if (has_verdict) verdict_q.push_back(fixed ? fixed_verdict : verdict);
  endtask

  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(9))
      0, 1, 2, 3: return 8'h61;
      4, 5, 6, 7: return 8'h62;
      default:    return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_mask_byte();
    case ($urandom_range(9))
      0, 1:    return STAR_BYTE;
      2:       return ANY_BYTE;
      3, 4, 5: return 8'h61;
      6, 7:    return 8'h62;
      8:       return 8'h63;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Send one text against the current mask, mostly one built to match it
  task automatic send_text();
    logic [7:0] txt [$];
    int n;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      for (int i = 0; i < pat_len; i++) begin
        if (pat_bytes[i] == STAR_BYTE) begin
          n = $urandom_range(3);
          repeat (n) txt.push_back(pick_text_byte());
        end else if (pat_bytes[i] == ANY_BYTE) begin
          txt.push_back(8'($urandom_range(255)));
        end else begin
          txt.push_back(pat_bytes[i]);
        end
      end
      // break a matching text now and then
      if (pick >= 55) begin
        case ($urandom_range(2))
          0: if (txt.size() > 0) txt.delete(txt.size() - 1);
          1: txt.push_back(pick_text_byte());
          default: if (txt.size() > 0) txt[$urandom_range(txt.size() - 1)] = pick_text_byte();
        endcase
      end
    end else begin
      n = $urandom_range(6);
      repeat (n) txt.push_back(pick_text_byte());
    end
    foreach (txt[i]) send_item(KIND_TEXT, txt[i], 1'b0, '0);
    send_item(KIND_END, 8'($urandom_range(255)), 1'b0, '0);
  endtask

  // Stimulus: directed table, then random sequences
  initial begin
    int n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      repeat (PLAN[r].reps)
        send_item(PLAN[r].kind, PLAN[r].ch, PLAN[r].fixed,
                  '{matched: PLAN[r].matched, overflow: PLAN[r].overflow});
    end

    pressure_go = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(19))
        0: begin
          // noise: arbitrary kinds and bytes
          n = $urandom_range(1, 6);
          repeat (n) send_item(wpm_kind_t'($urandom_range(3)), 8'($urandom_range(255)),
                               1'b0, '0);
        end
        1, 2, 3, 4, 5: begin
          // further texts against the mask already held
          send_text();
        end
        default: begin
          send_item(KIND_CLEAR, 8'($urandom_range(255)), 1'b0, '0);
          n = ($urandom_range(19) == 0) ? $urandom_range(28, 36) : $urandom_range(8);
          repeat (n) send_item(KIND_APPEND, pick_mask_byte(), 1'b0, '0);
          n = $urandom_range(1, 3);
          repeat (n) send_text();
        end
      endcase
    end

    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hold the receiver off for a long stretch so the block backs up
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Receiver stalls
  always @(posedge clk) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= RECV_IDLE[phase]);
  end

  // Compare each result transaction with the oldest expected verdict
  always @(posedge clk) begin
    match_verdict_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected result, tdata", m_axis_tdata, 0);
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata[0] !== want.matched)
          report_mismatch("matched", m_axis_tdata[0], want.matched);
        if (m_axis_tdata[1] !== want.overflow)
          report_mismatch("mask_overflow", m_axis_tdata[1], want.overflow);
        if (m_axis_tdata[7:2] !== 6'd0)
          report_mismatch("tdata padding", m_axis_tdata[7:2], 0);
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
